// ===== sv/magw_pkg.sv =====
// Shared types, codes and field widths for the multi-ant grid walker.
package magw_pkg;

  // Fixed field widths of the ports
  localparam int IN_X_W     = 11;
  localparam int IN_Y_W     = 10;
  localparam int HD_W       = 2;
  localparam int OUT_IDX_W  = 6;
  localparam int OUT_X_W    = 11;
  localparam int OUT_Y_W    = 10;
  localparam int CFG_W_W    = 12;
  localparam int CFG_H_W    = 11;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_W_W-1:0] GRID_WIDTH_RST  = 12'd1280;
  localparam logic [CFG_H_W-1:0] GRID_HEIGHT_RST = 11'd720;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  // Input actions
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Headings, clockwise from up
  localparam logic [HD_W-1:0] HD_UP    = 2'd0;
  localparam logic [HD_W-1:0] HD_RIGHT = 2'd1;
  localparam logic [HD_W-1:0] HD_DOWN  = 2'd2;
  localparam logic [HD_W-1:0] HD_LEFT  = 2'd3;

  typedef enum logic [1:0] {
    ST_STEP  = 2'd0,
    ST_ADD   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;
    logic cap_in;
    logic do_add;
    logic do_full;
    logic do_empty;
    logic ant_rd;
    logic load_pos;
    logic grid_rd;
    logic step_wr;
  } magw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic is_tick;
    logic table_full;
    logic no_ants;
    logic last_ant;
  } magw_sts_t;

endpackage

// ===== sv/magw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module magw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/magw_ctrl.sv =====
// Sequencing state machine for the multi-ant grid walker.
module magw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  output magw_pkg::magw_cmd_t   cmd,
  input  magw_pkg::magw_sts_t   sts
);

  import magw_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_MOVE   = 8'b0000_1000,
    S_GRD    = 8'b0001_0000,
    S_GWR    = 8'b0010_0000,
    S_SPARE0 = 8'b0100_0000,
    S_SPARE1 = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.is_tick) begin
          cmd.do_full = sts.table_full;
          cmd.do_add  = !sts.table_full;
          state_nxt   = S_IDLE;
        end else if (sts.no_ants) begin
          cmd.do_empty = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.ant_rd = 1'b1;
          state_nxt  = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd.load_pos = 1'b1;
        state_nxt    = S_GRD;
      end
      S_GRD: begin
        cmd.grid_rd = 1'b1;
        state_nxt   = S_GWR;
      end
      S_GWR: begin
        // write back this ant and, unless it is the last, prefetch the next one
        cmd.step_wr = 1'b1;
        if (sts.last_ant) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.ant_rd = 1'b1;
          state_nxt  = S_MOVE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== sv/magw_dp.sv =====
// Datapath of the multi-ant grid walker: registers, ant table, cell grid, results.
module magw_dp #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_ANTS   = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  magw_pkg::magw_cmd_t                   cmd,
  output magw_pkg::magw_sts_t                   sts,
  input  logic                                  cfg_we,
  input  logic [magw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [magw_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_action,
  input  logic [magw_pkg::IN_X_W-1:0]           in_start_x,
  input  logic [magw_pkg::IN_Y_W-1:0]           in_start_y,
  input  logic [magw_pkg::HD_W-1:0]             in_start_heading,
  output logic                                  out_strobe,
  output logic [magw_pkg::OUT_IDX_W-1:0]        out_ant_index,
  output logic [magw_pkg::OUT_X_W-1:0]          out_pos_x,
  output logic [magw_pkg::OUT_Y_W-1:0]          out_pos_y,
  output logic [magw_pkg::HD_W-1:0]             out_heading,
  output logic                                  out_cell_on,
  output logic [1:0]                            out_status,
  output logic                                  out_last
);

  import magw_pkg::*;

  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int IW        = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;
  localparam int CW        = $clog2(MAX_ANTS + 1);
  localparam int GRID_BITS = MAX_WIDTH * MAX_HEIGHT;
  localparam int GA        = $clog2(GRID_BITS);
  localparam int AWD       = XW + YW + HD_W;

  // Configuration
  logic [CFG_W_W-1:0] grid_width_r;
  logic [CFG_H_W-1:0] grid_height_r;
  logic [XW-1:0]      wm1;
  logic [YW-1:0]      hm1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Last usable column and row
  always_comb begin
    if (grid_width_r == '0) begin
      wm1 = '0;
    end else if (32'(grid_width_r) > MAX_WIDTH) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(grid_width_r - 1'b1);
    end
    if (grid_height_r == '0) begin
      hm1 = '0;
    end else if (32'(grid_height_r) > MAX_HEIGHT) begin
      hm1 = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = YW'(grid_height_r - 1'b1);
    end
  end

  // Captured input item
  logic              in_act_r;
  logic [IN_X_W-1:0] in_x_r;
  logic [IN_Y_W-1:0] in_y_r;
  logic [HD_W-1:0]   in_hd_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_act_r <= in_action;
      in_x_r   <= in_start_x;
      in_y_r   <= in_start_y;
      in_hd_r  <= in_start_heading;
    end
  end

  logic [XW-1:0] sx_c;
  logic [YW-1:0] sy_c;

  assign sx_c = (32'(in_x_r) > 32'(wm1)) ? wm1 : XW'(in_x_r);
  assign sy_c = (32'(in_y_r) > 32'(hm1)) ? hm1 : YW'(in_y_r);

  // Ant count and walk index
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.do_add) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.cap_in) begin
        idx_r <= '0;
      end else if (cmd.step_wr) begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  // Ant table
  logic           ant_we;
  logic [IW-1:0]  ant_waddr;
  logic [AWD-1:0] ant_wdata;
  logic [IW-1:0]  ant_raddr;
  logic [AWD-1:0] ant_rdata;

  // Stepping ant
  logic [XW-1:0]   x_r;
  logic [YW-1:0]   y_r;
  logic [HD_W-1:0] hd_r;
  logic            grid_q;
  logic [HD_W-1:0] hd_new;

  assign hd_new    = grid_q ? (hd_r - HD_W'(1)) : (hd_r + HD_W'(1));
  assign ant_we    = cmd.do_add | cmd.step_wr;
  assign ant_waddr = cmd.do_add ? IW'(cnt_r) : idx_r;
  assign ant_wdata = cmd.do_add ? {sx_c, sy_c, in_hd_r} : {x_r, y_r, hd_new};
  assign ant_raddr = cmd.step_wr ? (idx_r + IW'(1)) : idx_r;

  magw_ram #(
    .WIDTH (AWD),
    .DEPTH (MAX_ANTS)
  ) u_ant_ram (
    .clk   (clk),
    .we    (ant_we),
    .waddr (ant_waddr),
    .wdata (ant_wdata),
    .re    (cmd.ant_rd),
    .raddr (ant_raddr),
    .rdata (ant_rdata)
  );

  // Clamp to the current grid, then move one cell with wrap
  logic [XW-1:0]   ax, cx, nx;
  logic [YW-1:0]   ay, cy, ny;
  logic [HD_W-1:0] ahd;

  assign {ax, ay, ahd} = ant_rdata;
  assign cx = (ax > wm1) ? wm1 : ax;
  assign cy = (ay > hm1) ? hm1 : ay;

  always_comb begin
    nx = cx;
    ny = cy;
    case (ahd)
      HD_UP:    ny = (cy == '0) ? hm1 : (cy - YW'(1));
      HD_RIGHT: nx = (cx >= wm1) ? '0 : (cx + XW'(1));
      HD_DOWN:  ny = (cy >= hm1) ? '0 : (cy + YW'(1));
      HD_LEFT:  nx = (cx == '0) ? wm1 : (cx - XW'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pos) begin
      x_r  <= nx;
      y_r  <= ny;
      hd_r <= ahd;
    end
  end

  // Cell grid
  logic [GA-1:0] clr_cnt_r;
  logic [GA-1:0] g_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt_r <= clr_cnt_r + GA'(1);
    end
  end

  assign g_addr = GA'(y_r) * GA'(MAX_WIDTH) + GA'(x_r);

  magw_ram #(
    .WIDTH (1),
    .DEPTH (GRID_BITS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (cmd.clear_step | cmd.step_wr),
    .waddr (cmd.clear_step ? clr_cnt_r : g_addr),
    .wdata (cmd.clear_step ? 1'b0 : ~grid_q),
    .re    (cmd.grid_rd),
    .raddr (g_addr),
    .rdata (grid_q)
  );

  // Status to the controller
  assign sts.clear_done = (clr_cnt_r == GA'(GRID_BITS - 1));
  assign sts.is_tick    = (in_act_r == ACT_TICK);
  assign sts.table_full = (cnt_r == CW'(MAX_ANTS));
  assign sts.no_ants    = (cnt_r == '0);
  assign sts.last_ant   = ((CW'(idx_r) + CW'(1)) == cnt_r);

  // Result registers
  logic                 out_strobe_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic [OUT_X_W-1:0]   out_x_r;
  logic [OUT_Y_W-1:0]   out_y_r;
  logic [HD_W-1:0]      out_hd_r;
  logic                 out_on_r;
  status_t              out_status_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.do_add | cmd.do_full | cmd.do_empty | cmd.step_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_wr) begin
      out_idx_r    <= OUT_IDX_W'(idx_r);
      out_x_r      <= OUT_X_W'(x_r);
      out_y_r      <= OUT_Y_W'(y_r);
      out_hd_r     <= hd_new;
      out_on_r     <= ~grid_q;
      out_status_r <= ST_STEP;
      out_last_r   <= sts.last_ant;
    end else if (cmd.do_add) begin
      out_idx_r    <= OUT_IDX_W'(cnt_r);
      out_x_r      <= OUT_X_W'(sx_c);
      out_y_r      <= OUT_Y_W'(sy_c);
      out_hd_r     <= in_hd_r;
      out_on_r     <= 1'b0;
      out_status_r <= ST_ADD;
      out_last_r   <= 1'b1;
    end else if (cmd.do_full | cmd.do_empty) begin
      out_idx_r    <= '0;
      out_x_r      <= '0;
      out_y_r      <= '0;
      out_hd_r     <= '0;
      out_on_r     <= 1'b0;
      out_status_r <= cmd.do_full ? ST_FULL : ST_EMPTY;
      out_last_r   <= 1'b1;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_ant_index = out_idx_r;
  assign out_pos_x     = out_x_r;
  assign out_pos_y     = out_y_r;
  assign out_heading   = out_hd_r;
  assign out_cell_on   = out_on_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

endmodule

// ===== sv/multi_ant_grid_walker.sv =====
// Top level of the multi-ant grid walker: controller, datapath and checks.
//
// Usage:
//   Input: drive in_action and the start fields and raise start; the item
//   transfers at a clock edge where start is high and busy is low.
//   Results: each result shows on the out_ ports for one cycle with
//   out_strobe high; the receiver cannot hold them off. out_last marks the
//   final result of an item.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index at the clock
//   edge (0 = grid_width, 1 = grid_height). Write only while busy is low.
// Sequencing:
//   An add, a full-table add or a tick with no ants gives its one result
//   from the decode state through the result registers. A tick walks the
//   ants in turn: each ant needs an ant-table read, a grid read and a
//   grid/table write-back, as grid read data is registered, and the next
//   ant's table read overlaps the write-back. busy drops in the cycle the
//   final result shows.
// Reset:
//   rst_n is synchronous. After reset the block sweeps the cell grid clear,
//   one cell per cycle, with busy high; configuration writes are taken
//   meanwhile.
module multi_ant_grid_walker #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_ANTS   = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_action,
  input  logic [magw_pkg::IN_X_W-1:0]      in_start_x,
  input  logic [magw_pkg::IN_Y_W-1:0]      in_start_y,
  input  logic [magw_pkg::HD_W-1:0]        in_start_heading,
  input  logic                             cfg_we,
  input  logic [magw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [magw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                             out_strobe,
  output logic [magw_pkg::OUT_IDX_W-1:0]   out_ant_index,
  output logic [magw_pkg::OUT_X_W-1:0]     out_pos_x,
  output logic [magw_pkg::OUT_Y_W-1:0]     out_pos_y,
  output logic [magw_pkg::HD_W-1:0]        out_heading,
  output logic                             out_cell_on,
  output logic [1:0]                       out_status,
  output logic                             out_last
);

  import magw_pkg::*;

  magw_cmd_t cmd;
  magw_sts_t sts;

  // Controller sequences clear, decode and the per-ant walk
  magw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Datapath holds config, ant table, cell grid and result registers
  magw_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_ANTS   (MAX_ANTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_action        (in_action),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_start_heading (in_start_heading),
    .out_strobe       (out_strobe),
    .out_ant_index    (out_ant_index),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_heading      (out_heading),
    .out_cell_on      (out_cell_on),
    .out_status       (out_status),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // A transfer always starts work
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer taken but block not busy");

  // Single-result items always close the item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_STEP)) |-> out_last)
    else $error("single result without last");

  // The block is free again when the final result shows
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> !busy)
    else $error("busy still high on final result");

  // Grid write-back, adds and input capture never overlap the clearing sweep
  a_no_step_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> !(cmd.step_wr || cmd.do_add || cmd.cap_in))
    else $error("item work during grid clear");
`endif

endmodule
